/* hw/rtl/otsu_pkg.sv */
// Shared types, widths and codes for the Otsu threshold binarizer.
`default_nettype none
package otsu_pkg;
  localparam int BINS      = 256;
  localparam int PIX_W     = 8;
  localparam int CMD_W     = 2;
  localparam int N_W       = 21;
  localparam int M_W       = 28;
  localparam int Q_W       = N_W + M_W;
  localparam int D_W       = Q_W;
  localparam int P_W       = 2 * N_W;
  localparam int D2_W      = 2 * D_W;
  localparam int PR_W      = D2_W + P_W;
  localparam int MB_W      = D_W;
  localparam int MUL_STEPS = MB_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  localparam logic [N_W-1:0]   MAX_PIXELS = N_W'(1048576);
  localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;
  localparam logic [PIX_W-1:0] THR_RESET  = 8'd128;

  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_THR   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLS   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

  typedef enum logic [1:0] {MS_SQ, MS_LHS, MS_RHS} mul_sel_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_ACC, ST_RD, ST_LD, ST_DIF, ST_A, ST_B, ST_P, ST_D,
    ST_SQL, ST_SQ, ST_SEL, ST_LHL, ST_LH, ST_RHL, ST_RH, ST_CMP, ST_NXT, ST_FIN
  } state_t;

  typedef struct packed {
    logic     acc_go;
    logic     drop;
    logic     cls_go;
    logic     bin_clr;
    logic     bin_inc;
    logic     rd_en;
    logic     rd_bin;
    logic     wr_zero;
    logic     wr_inc;
    logic     ld_bin;
    logic     dif;
    logic     q_a;
    logic     q_b;
    logic     q_p;
    logic     d_go;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     mul_run;
    logic     sq_save;
    logic     take_first;
    logic     lhs_save;
    logic     cmp_go;
    logic     fin;
  } dp_cmd_t;

  typedef struct packed {
    logic room;
    logic skip;
    logic mul_last;
    logic bin_last;
    logic have;
    logic out_busy;
  } dp_sta_t;
endpackage
`default_nettype wire

/* hw/rtl/otsu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module otsu_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/otsu_dp.sv */
// Datapath: histogram RAM, frame sums, Otsu score arithmetic and result register.
`default_nettype none
module otsu_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [otsu_pkg::PIX_W-1:0]  in_pixel,
  input  wire logic                        out_ready,
  input  wire otsu_pkg::dp_cmd_t           cmd,
  output otsu_pkg::dp_sta_t                sta,
  output logic                             out_valid,
  output logic      [otsu_pkg::PIX_W-1:0]  out_value,
  output logic                             out_is_threshold,
  output logic                             out_empty_image,
  output logic                             out_overflow
);
  import otsu_pkg::*;

  logic [N_W-1:0]   pixtot_r, n1_r, n2_r, rd_data, wr_data;
  logic [M_W-1:0]   msum_r, m1_r, m2_r, bh, q_x;
  logic [N_W-1:0]   q_y;
  logic [Q_W-1:0]   q_prod, a_r, b_r;
  logic [D_W-1:0]   d_r;
  logic [P_W-1:0]   p_r, bp_r;
  logic [D2_W-1:0]  d2_r, bd2_r;
  logic [PR_W-1:0]  lhs_r, acc_r, ma_r;
  logic [MB_W-1:0]  mb_r;
  logic [CNT_W-1:0] mcnt_r;
  logic [PIX_W-1:0] pix_r, bin_r, thr_r, bt_r, thr_nxt, rd_addr, wr_addr;
  logic             drop_r, have_r, out_valid_r;
  logic [PIX_W-1:0] out_value_r;
  logic             out_thr_r, out_empty_r, out_ovf_r;

  assign rd_addr = cmd.rd_bin ? bin_r : in_pixel;
  assign wr_addr = cmd.wr_inc ? pix_r : bin_r;
  assign wr_data = cmd.wr_inc ? rd_data + N_W'(1) : '0;

  otsu_ram #(.WIDTH(N_W), .DEPTH(BINS)) u_hist (
    .clk     (clk),
    .wr_en   (cmd.wr_zero | cmd.wr_inc),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign bh = M_W'(bin_r) * M_W'(rd_data);

  always_comb begin
    q_x = m1_r;
    q_y = n2_r;
    if (cmd.q_b) begin
      q_x = m2_r;
      q_y = n1_r;
    end else if (cmd.q_p) begin
      q_x = M_W'(n1_r);
      q_y = n2_r;
    end
  end
  assign q_prod = Q_W'(q_x) * Q_W'(q_y);

  assign thr_nxt = (bt_r == '0) ? PIX_W'(1) : bt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixtot_r    <= '0;
      msum_r      <= '0;
      drop_r      <= 1'b0;
      thr_r       <= THR_RESET;
      bin_r       <= '0;
      have_r      <= 1'b0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cls_go || cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.acc_go) begin
        pixtot_r <= pixtot_r + N_W'(1);
        msum_r   <= msum_r + M_W'(in_pixel);
        pix_r    <= in_pixel;
      end
      if (cmd.drop) begin
        drop_r <= 1'b1;
      end
      if (cmd.cls_go) begin
        out_value_r <= (in_pixel >= thr_r) ? PIX_MAX : '0;
        out_thr_r   <= 1'b0;
        out_empty_r <= 1'b0;
        out_ovf_r   <= drop_r;
      end
      if (cmd.bin_clr) begin
        bin_r  <= '0;
        have_r <= 1'b0;
        n1_r   <= '0;
        m1_r   <= '0;
        bt_r   <= '0;
      end else if (cmd.bin_inc) begin
        bin_r <= bin_r + PIX_W'(1);
      end
      if (cmd.ld_bin) begin
        n1_r <= n1_r + rd_data;
        m1_r <= m1_r + bh;
      end
      if (cmd.dif) begin
        n2_r <= pixtot_r - n1_r;
        m2_r <= msum_r - m1_r;
      end
      if (cmd.q_a) a_r <= q_prod;
      if (cmd.q_b) b_r <= q_prod;
      if (cmd.q_p) p_r <= q_prod[P_W-1:0];
      if (cmd.d_go) begin
        d_r <= (a_r > b_r) ? a_r - b_r : b_r - a_r;
      end
      if (cmd.mul_load) begin
        acc_r  <= '0;
        mcnt_r <= '0;
        case (cmd.mul_sel)
          MS_SQ: begin
            ma_r <= PR_W'(d_r);
            mb_r <= d_r;
          end
          MS_LHS: begin
            ma_r <= PR_W'(d2_r);
            mb_r <= MB_W'(bp_r);
          end
          MS_RHS: begin
            ma_r <= PR_W'(bd2_r);
            mb_r <= MB_W'(p_r);
          end
          default: begin
            ma_r <= '0;
            mb_r <= '0;
          end
        endcase
      end else if (cmd.mul_run) begin
        if (mb_r[0]) begin
          acc_r <= acc_r + ma_r;
        end
        ma_r   <= ma_r << 1;
        mb_r   <= mb_r >> 1;
        mcnt_r <= mcnt_r + CNT_W'(1);
      end
      if (cmd.sq_save) begin
        d2_r <= acc_r[D2_W-1:0];
      end
      if (cmd.take_first) begin
        bd2_r  <= acc_r[D2_W-1:0];
        bp_r   <= p_r;
        bt_r   <= bin_r;
        have_r <= 1'b1;
      end
      if (cmd.lhs_save) begin
        lhs_r <= acc_r;
      end
      if (cmd.cmp_go && (lhs_r > acc_r)) begin
        bd2_r <= d2_r;
        bp_r  <= p_r;
        bt_r  <= bin_r;
      end
      if (cmd.fin) begin
        thr_r       <= thr_nxt;
        out_value_r <= thr_nxt;
        out_thr_r   <= 1'b1;
        out_empty_r <= (pixtot_r == '0);
        out_ovf_r   <= drop_r;
        pixtot_r    <= '0;
        msum_r      <= '0;
        drop_r      <= 1'b0;
      end
    end
  end

  assign sta.room     = (pixtot_r < MAX_PIXELS);
  assign sta.skip     = (n1_r == '0) || (n2_r == '0);
  assign sta.mul_last = (mcnt_r == CNT_W'(MUL_STEPS - 1));
  assign sta.bin_last = (bin_r == PIX_W'(BINS - 1));
  assign sta.have     = have_r;
  assign sta.out_busy = out_valid_r & ~out_ready;

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_is_threshold = out_thr_r;
  assign out_empty_image  = out_empty_r;
  assign out_overflow     = out_ovf_r;
endmodule
`default_nettype wire

/* hw/rtl/otsu_ctrl.sv */
// Controller: sequences histogram clear, accumulate and the per-bin Otsu search.
`default_nettype none
module otsu_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [otsu_pkg::CMD_W-1:0]  in_command,
  output logic                             in_ready,
  input  wire otsu_pkg::dp_sta_t           sta,
  output otsu_pkg::dp_cmd_t                cmd
);
  import otsu_pkg::*;

  state_t st_r, st_nxt;
  logic   acc;

  assign in_ready = (st_r == ST_IDLE) && !sta.out_busy;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLR:  if (sta.bin_last) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc && in_command == CMD_ACC && sta.room) st_nxt = ST_ACC;
        else if (acc && in_command == CMD_THR)        st_nxt = ST_RD;
      end
      ST_ACC:  st_nxt = ST_IDLE;
      ST_RD:   st_nxt = ST_LD;
      ST_LD:   st_nxt = ST_DIF;
      ST_DIF:  st_nxt = ST_A;
      ST_A:    st_nxt = sta.skip ? ST_NXT : ST_B;
      ST_B:    st_nxt = ST_P;
      ST_P:    st_nxt = ST_D;
      ST_D:    st_nxt = ST_SQL;
      ST_SQL:  st_nxt = ST_SQ;
      ST_SQ:   if (sta.mul_last) st_nxt = ST_SEL;
      ST_SEL:  st_nxt = sta.have ? ST_LHL : ST_NXT;
      ST_LHL:  st_nxt = ST_LH;
      ST_LH:   if (sta.mul_last) st_nxt = ST_RHL;
      ST_RHL:  st_nxt = ST_RH;
      ST_RH:   if (sta.mul_last) st_nxt = ST_CMP;
      ST_CMP:  st_nxt = ST_NXT;
      ST_NXT:  st_nxt = sta.bin_last ? ST_FIN : ST_RD;
      ST_FIN:  st_nxt = sta.out_busy ? ST_FIN : ST_IDLE;
      default: st_nxt = ST_CLR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (st_r)
      ST_CLR: begin
        cmd.wr_zero = 1'b1;
        cmd.bin_inc = ~sta.bin_last;
        cmd.bin_clr = sta.bin_last;
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_command)
            CMD_ACC: begin
              cmd.acc_go = sta.room;
              cmd.rd_en  = sta.room;
              cmd.drop   = ~sta.room;
            end
            CMD_THR: cmd.bin_clr = 1'b1;
            CMD_CLS: cmd.cls_go  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ACC: cmd.wr_inc = 1'b1;
      ST_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_bin = 1'b1;
      end
      ST_LD: begin
        cmd.ld_bin  = 1'b1;
        cmd.wr_zero = 1'b1;
      end
      ST_DIF:  cmd.dif = 1'b1;
      ST_A:    cmd.q_a = ~sta.skip;
      ST_B:    cmd.q_b = 1'b1;
      ST_P:    cmd.q_p = 1'b1;
      ST_D:    cmd.d_go = 1'b1;
      ST_SQL: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MS_SQ;
      end
      ST_SQ:   cmd.mul_run = 1'b1;
      ST_SEL: begin
        cmd.sq_save    = 1'b1;
        cmd.take_first = ~sta.have;
      end
      ST_LHL: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MS_LHS;
      end
      ST_LH:   cmd.mul_run = 1'b1;
      ST_RHL: begin
        cmd.lhs_save = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MS_RHS;
      end
      ST_RH:   cmd.mul_run = 1'b1;
      ST_CMP:  cmd.cmp_go = 1'b1;
      ST_NXT:  cmd.bin_inc = ~sta.bin_last;
      ST_FIN:  cmd.fin = ~sta.out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/otsu_threshold_binarizer.sv */
// Top level of the Otsu threshold binarizer.
// After reset all 256 bins of the histogram RAM are cleared, during which no
// transaction is accepted. An accumulate transaction reads the histogram bin,
// then writes it back incremented; a classify transaction registers its result
// when accepted, and an unknown command is accepted and ignored. A threshold
// transaction scans all 256 bins and clears each bin as it goes; a bin with an
// empty class is not scored. The search time is set by the 49-step bit-serial
// multiplier, used once for the first scored bin and three times for every
// later scored bin for the exact cross-multiplied variance compare. Results
// sit in an output register; the next transaction is taken while a result
// waits, unless it is still stalled, and a finished search holds its
// threshold until that register is free.
`default_nettype none
module otsu_threshold_binarizer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [otsu_pkg::CMD_W-1:0]  in_command,
  input  wire logic [otsu_pkg::PIX_W-1:0]  in_pixel,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [otsu_pkg::PIX_W-1:0]  out_value,
  output logic                             out_is_threshold,
  output logic                             out_empty_image,
  output logic                             out_overflow
);
  import otsu_pkg::*;

  dp_cmd_t cmd;
  dp_sta_t sta;

  otsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .sta        (sta),
    .cmd        (cmd)
  );

  otsu_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_pixel         (in_pixel),
    .out_ready        (out_ready),
    .cmd              (cmd),
    .sta              (sta),
    .out_valid        (out_valid),
    .out_value        (out_value),
    .out_is_threshold (out_is_threshold),
    .out_empty_image  (out_empty_image),
    .out_overflow     (out_overflow)
  );
endmodule
`default_nettype wire

/* hw/rtl/otsu_chk.sv */
// Port-level checker for the Otsu threshold binarizer, bound to the top level.
`default_nettype none
module otsu_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [otsu_pkg::CMD_W-1:0] in_command,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [otsu_pkg::PIX_W-1:0] out_value,
  input wire logic                       out_is_threshold,
  input wire logic                       out_empty_image
);
  import otsu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_is_threshold))
    else $error("result transaction changed while stalled");

  a_thr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_threshold |-> out_value != '0)
    else $error("threshold of zero reported");

  a_cls_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_threshold |-> (out_value == '0 || out_value == PIX_MAX)
      && !out_empty_image)
    else $error("classify result not binary");

  a_empty_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_image |-> out_is_threshold && out_value == PIX_W'(1))
    else $error("empty image without threshold of one");

  a_cls_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_CLS |=> out_valid && !out_is_threshold)
    else $error("classify transaction gave no result");
endmodule

bind otsu_threshold_binarizer otsu_chk u_chk (.*);
`default_nettype wire

/* bench/otsu_result_checker.sv */
// Result checker for the Otsu threshold binarizer: histogram predictor and scoreboard.
`timescale 1ns / 100ps
module otsu_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [otsu_pkg::CMD_W-1:0] in_command,
  input  logic [otsu_pkg::PIX_W-1:0] in_pixel,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [otsu_pkg::PIX_W-1:0] out_value,
  input  logic                       out_is_threshold,
  input  logic                       out_empty_image,
  input  logic                       out_overflow,
  output int                         fail_count,
  output int                         pending
);
  import otsu_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             is_thr;
    logic             empty;
    logic             ovf;
  } otsu_result_t;

  logic [N_W-1:0]   bin_count [BINS];
  logic [N_W-1:0]   frame_total;
  logic             lost_pixels;
  logic [PIX_W-1:0] cur_thr;
  otsu_result_t     expected_q [$];

  function automatic logic [PIX_W-1:0] otsu_pick();
    logic [63:0]  n, m, n1, m1, n2, m2, a, b, d, p, best_d, best_p;
    logic [191:0] lhs, rhs;
    logic         have;
    logic [7:0]   best_t;
    n = 0; m = 0; n1 = 0; m1 = 0; best_d = 0; best_p = 0; have = 0; best_t = 0;
    for (int i = 0; i < BINS; i++) begin
      n += bin_count[i];
      m += 64'(i) * bin_count[i];
    end
    for (int i = 0; i < BINS; i++) begin
      n1 += bin_count[i];
      m1 += 64'(i) * bin_count[i];
      n2 = n - n1;
      m2 = m - m1;
      if (n1 != 0 && n2 != 0) begin
        a = m1 * n2;
        b = m2 * n1;
        d = (a > b) ? a - b : b - a;
        p = n1 * n2;
        lhs = 192'(d) * 192'(d) * 192'(best_p);
        rhs = 192'(best_d) * 192'(best_d) * 192'(p);
        if (!have || lhs > rhs) begin
          have = 1; best_d = d; best_p = p; best_t = 8'(i);
        end
      end
    end
    return best_t;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    otsu_result_t exp_r, got;
    logic [PIX_W-1:0] t;
    if (!rst_n) begin
      foreach (bin_count[i]) bin_count[i] = '0;
      frame_total = '0;
      lost_pixels = 0;
      cur_thr = THR_RESET;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        case (in_command)
          CMD_ACC: begin
            if (frame_total < MAX_PIXELS) begin
              bin_count[in_pixel]++;
              frame_total++;
            end else lost_pixels = 1;
          end
          CMD_THR: begin
            t = otsu_pick();
            if (t == 0) t = 1;
            cur_thr = t;
            expected_q.push_back('{t, 1'b1, frame_total == 0, lost_pixels});
            foreach (bin_count[i]) bin_count[i] = '0;
            frame_total = '0;
            lost_pixels = 0;
          end
          CMD_CLS: begin
            expected_q.push_back('{(in_pixel >= cur_thr) ? PIX_MAX : 8'd0, 1'b0, 1'b0,
                                   lost_pixels});
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{out_value, out_is_threshold, out_empty_image, out_overflow};
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction, actual %p", $time, got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
          end
        end
      end
    end
  end
endmodule

/* bench/tb_otsu_threshold_binarizer.sv */
// Testbench top for the Otsu threshold binarizer: stimulus, handshake pressure, verdict.
`timescale 1ns / 100ps
module tb_otsu_threshold_binarizer;
  import otsu_pkg::*;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_ready;
  logic [CMD_W-1:0] in_command = CMD_ACC;
  logic [PIX_W-1:0] in_pixel = '0;
  logic             out_valid;
  logic             out_ready = 0;
  logic [PIX_W-1:0] out_value;
  logic             out_is_threshold, out_empty_image, out_overflow;
  int               fail_count, pending;
  logic             idle_on = 1;
  logic             hold_req = 0;
  logic             hold_done = 0;
  int               hold_cnt = 0;
  int               rx_gap = 0;
  int               stuck_cycles = 0;

  always #6 clk = ~clk;

  otsu_threshold_binarizer u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_pixel,
    .out_valid, .out_ready, .out_value, .out_is_threshold, .out_empty_image, .out_overflow
  );

  otsu_result_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_pixel,
    .out_valid, .out_ready, .out_value, .out_is_threshold, .out_empty_image, .out_overflow,
    .fail_count, .pending
  );

  // receiver: long hold on request, otherwise random stall bursts while idle_on is set
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_ready <= 0;
      if (hold_cnt == 400) hold_done <= 1;
      hold_cnt <= hold_cnt + 1;
    end else if (rx_gap > 0) begin
      out_ready <= 0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1;
      if (idle_on && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 6);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles > 200000) begin
      $display("[otsu_threshold_binarizer] ERROR");
      $finish;
    end
  end

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [PIX_W-1:0] pix);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_pixel <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int cnt, base, span;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: reset threshold, empty frame, single level, extremes, unknown command
    send(CMD_CLS, 8'd127); send(CMD_CLS, 8'd128);
    send(CMD_CLS, 8'd0);   send(CMD_CLS, 8'd255);
    send(CMD_THR, 8'd0);
    send(CMD_CLS, 8'd0);   send(CMD_CLS, 8'd1);
    send(CMD_ACC, 8'd77);  send(CMD_ACC, 8'd77); send(CMD_ACC, 8'd77);
    send(CMD_THR, 8'd255);
    send(CMD_ACC, 8'd0);   send(CMD_ACC, 8'd255); send(CMD_ACC, 8'd255);
    send(CMD_UNDEF, 8'd10); send(CMD_UNDEF, 8'hAA);
    send(CMD_THR, 8'd0);
    send(CMD_CLS, 8'd254); send(CMD_CLS, 8'd255); send(CMD_UNDEF, 8'h55);
    drain();

    // long receiver stall while classify traffic keeps coming
    hold_req = 1;
    for (int i = 0; i < 30; i++) send(CMD_CLS, 8'($urandom_range(0, 255)));
    drain();

    // random frames: mostly narrow pixel spreads, a few wide
    for (int f = 0; f < 45; f++) begin
      if (f == 36) idle_on = 0;
      span = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 12);
      base = $urandom_range(0, 255 - span);
      cnt = $urandom_range(0, 10);
      for (int i = 0; i < cnt; i++) begin
        if ($urandom_range(0, 15) == 0) send(CMD_UNDEF, 8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 9) == 0) send(CMD_CLS, 8'($urandom_range(0, 255)));
        else send(CMD_ACC, 8'(base + $urandom_range(0, span)));
      end
      send(CMD_THR, 8'($urandom_range(0, 255)));
      for (int i = 0; i < 2; i++) send(CMD_CLS, 8'($urandom_range(0, 255)));
      if (f == 10) drain();
    end
    drain();

    send(CMD_CLS, 8'd200);
    send(CMD_THR, 8'd0);
    send(CMD_CLS, 8'd200);
    drain();

    if (fail_count == 0) $display("[otsu_threshold_binarizer] OK");
    else $display("[otsu_threshold_binarizer] ERROR");
    $finish;
  end
endmodule

/* otsu_threshold_binarizer.f */
hw/rtl/otsu_pkg.sv
hw/rtl/otsu_ram.sv
hw/rtl/otsu_dp.sv
hw/rtl/otsu_ctrl.sv
hw/rtl/otsu_threshold_binarizer.sv
hw/rtl/otsu_chk.sv
bench/otsu_result_checker.sv
bench/tb_otsu_threshold_binarizer.sv
